// ===== sv/dual_phase_current_pi_control_macros.svh =====
// assertion macros shared by the current controller checker
`ifndef DUAL_PHASE_CURRENT_PI_CONTROL_MACROS_SVH
`define DUAL_PHASE_CURRENT_PI_CONTROL_MACROS_SVH

// clocked check, ignored while reset is asserted
`define DPCPI_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define DPCPI_ASSERT_ANY(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/dpcpi_pkg.sv =====
// shared constants, control structs and result type of the current controller
package dpcpi_pkg;

    // sample and fixed-point formats
    localparam int SAMPLE_BITS = 12;
    localparam int FRAC_BITS   = 8;
    localparam int ACC_W       = 32;
    localparam int DUTY_W      = 40;
    localparam int FIELD_W     = 17;

    // sensor scaling, voltages in 0.1 mV, sensitivity in 0.1 mV per ampere
    localparam longint SAMPLE_MAX  = (longint'(1) << SAMPLE_BITS) - 1;
    localparam longint SENS_UNITS  = 419;
    localparam longint BUCK_FS     = 33000;
    localparam longint BOOST_FS    = 66000;
    localparam longint BUCK_OFF    = 200;
    localparam longint BOOST_OFF   = 25000;
    localparam longint DEN         = SAMPLE_MAX * SENS_UNITS;
    localparam longint DEN2        = 2 * DEN;
    localparam longint SCALE2      = longint'(2) << FRAC_BITS;

    // quotient bias keeps the dividend non-negative
    localparam longint QUOT_BIAS   = 16384;

    // dividend = coef_a * code + coef_b, already doubled for round half up
    localparam longint A_BUCK  = SCALE2 * BUCK_FS;
    localparam longint A_BOOST = SCALE2 * BOOST_FS;
    localparam longint B_BUCK  = DEN - SCALE2 * BUCK_OFF * SAMPLE_MAX + QUOT_BIAS * DEN2;
    localparam longint B_BOOST = DEN - SCALE2 * BOOST_OFF * SAMPLE_MAX + QUOT_BIAS * DEN2;

    // reciprocal divide datapath widths
    localparam int X_W       = 38;
    localparam int Y_SHIFT   = 12;
    localparam int Y_W       = X_W - Y_SHIFT;
    localparam int RCP_SHIFT = 36;
    localparam int RCP_W     = 27;
    localparam int PROD_W    = Y_W + RCP_W;
    localparam int Q_W       = 16;
    localparam int DEN2_W    = 22;
    localparam int COEF_W    = 26;
    localparam int CUR_W     = Q_W + 1;

    localparam longint RECIP = (longint'(1) << (RCP_SHIFT + Y_SHIFT)) / DEN2;

    localparam logic [COEF_W-1:0] A_BUCK_C  = COEF_W'(A_BUCK);
    localparam logic [COEF_W-1:0] A_BOOST_C = COEF_W'(A_BOOST);
    localparam logic [X_W-1:0]    B_BUCK_C  = X_W'(B_BUCK);
    localparam logic [X_W-1:0]    B_BOOST_C = X_W'(B_BOOST);
    localparam logic [RCP_W-1:0]  RECIP_C   = RCP_W'(RECIP);
    localparam logic [DEN2_W-1:0] DEN2_C    = DEN2_W'(DEN2);

    // setpoints in 1/256 A, boost value rounded half up
    localparam longint SETPOINT_BUCK  = longint'(16) << FRAC_BITS;
    localparam longint SETPOINT_BOOST =
        -((2 * 1632 * (longint'(1) << FRAC_BITS) - 100 + 199) / 200);

    // Q16 gains
    localparam int KP_W = 22;
    localparam int KI_W = 13;
    localparam logic [KP_W-1:0] KP_BUCK  = KP_W'(3604480);
    localparam logic [KI_W-1:0] KI_BUCK  = KI_W'(3277);
    localparam logic [KP_W-1:0] KP_BOOST = KP_W'(655360);
    localparam logic [KI_W-1:0] KI_BOOST = KI_W'(6554);

    // PI product and sum widths
    localparam int PKP_W       = KP_W + 1 + FIELD_W;
    localparam int PKI_W       = KI_W + 1 + ACC_W;
    localparam int SUM_W       = 48;
    localparam int ROUND_SHIFT = 16;

    // stages from input register to merge output
    localparam int PIPE_STAGES = 6;

    typedef struct packed {
        logic advance;
        logic boost;
    } lane_ctl_t;

    typedef struct packed {
        logic advance;
        logic acc_load;
        logic boost;
    } merge_ctl_t;

    typedef struct packed {
        logic                      limit_flag;
        logic signed [FIELD_W-1:0] control_error;
        logic signed [FIELD_W-1:0] total_current;
        logic signed [DUTY_W-1:0]  duty_command;
    } result_t;

endpackage

// ===== sv/dpcpi_lane.sv =====
// one phase lane: ADC code to current by reciprocal multiply and correction
module dpcpi_lane (
    input  logic                                    clk,
    input  dpcpi_pkg::lane_ctl_t                    ctl,
    input  logic [dpcpi_pkg::SAMPLE_BITS-1:0]       code,
    output logic signed [dpcpi_pkg::CUR_W-1:0]      current
);

    logic [dpcpi_pkg::COEF_W-1:0] coef_a;
    logic [dpcpi_pkg::X_W-1:0]    coef_b;
    logic [dpcpi_pkg::X_W-1:0]    x_reg, x_next, x2_reg, x3_reg;
    logic [dpcpi_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [dpcpi_pkg::Q_W-1:0]    qe_reg;
    logic [dpcpi_pkg::X_W-1:0]    chk_reg, chk_next;
    logic [dpcpi_pkg::X_W-1:0]    rem;
    logic [dpcpi_pkg::Q_W-1:0]    quot;
    logic signed [dpcpi_pkg::CUR_W-1:0] cur_reg, cur_next;

    // biased dividend from the mode's scale and offset
    always_comb
    begin
        coef_a = ctl.boost ? dpcpi_pkg::A_BOOST_C : dpcpi_pkg::A_BUCK_C;
        coef_b = ctl.boost ? dpcpi_pkg::B_BOOST_C : dpcpi_pkg::B_BUCK_C;
        x_next = coef_a * code + coef_b;
    end

    // quotient estimate from the upper dividend bits
    assign prod_next = x_reg[dpcpi_pkg::X_W-1:dpcpi_pkg::Y_SHIFT] * dpcpi_pkg::RECIP_C;

    // back-multiply the estimate
    assign chk_next = prod_reg[dpcpi_pkg::RCP_SHIFT +: dpcpi_pkg::Q_W] * dpcpi_pkg::DEN2_C;

    // estimate is low by at most one, fix it and remove the bias
    always_comb
    begin
        rem      = x3_reg - chk_reg;
        quot     = qe_reg + dpcpi_pkg::Q_W'(rem >= dpcpi_pkg::X_W'(dpcpi_pkg::DEN2));
        cur_next = $signed({1'b0, quot}) - $signed(dpcpi_pkg::CUR_W'(dpcpi_pkg::QUOT_BIAS));
    end

    // lane pipeline registers
    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            x_reg    <= x_next;
            prod_reg <= prod_next;
            x2_reg   <= x_reg;
            qe_reg   <= prod_reg[dpcpi_pkg::RCP_SHIFT +: dpcpi_pkg::Q_W];
            chk_reg  <= chk_next;
            x3_reg   <= x2_reg;
            cur_reg  <= cur_next;
        end
    end

    assign current = cur_reg;

endmodule

// ===== sv/dpcpi_merge.sv =====
// merge stage: total current, error, saturating accumulator and PI output
module dpcpi_merge (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  dpcpi_pkg::merge_ctl_t                   ctl,
    input  logic signed [dpcpi_pkg::CUR_W-1:0]      cur_a,
    input  logic signed [dpcpi_pkg::CUR_W-1:0]      cur_b,
    output dpcpi_pkg::result_t                      result
);

    localparam int FW = dpcpi_pkg::FIELD_W;
    localparam int AW = dpcpi_pkg::ACC_W;
    localparam int DW = dpcpi_pkg::DUTY_W;
    localparam int SW = dpcpi_pkg::SUM_W;

    logic signed [dpcpi_pkg::CUR_W:0] tot_wide;
    logic signed [FW-1:0]             tot_sat;
    logic signed [FW:0]               setpoint;
    logic signed [FW:0]               err_wide;
    logic signed [FW-1:0]             err_sat;
    logic signed [AW:0]               acc_wide;
    logic signed [AW-1:0]             acc_sat;
    logic                             acc_hit;

    logic signed [FW-1:0]             total_reg, total2_reg;
    logic signed [FW-1:0]             err_reg, err2_reg;
    logic signed [AW-1:0]             acc_reg, acc_next;
    logic                             aflag_reg, aflag2_reg;
    logic                             boost2_reg;

    logic [dpcpi_pkg::KP_W-1:0]       kp;
    logic [dpcpi_pkg::KI_W-1:0]       ki;
    logic signed [dpcpi_pkg::PKP_W-1:0] pkp_reg, pkp_next;
    logic signed [dpcpi_pkg::PKI_W-1:0] pki_reg, pki_next;

    logic signed [SW-1:0]             sum;
    logic signed [SW-1:0]             sum_sel;
    logic signed [SW-1:0]             sum_rnd;
    logic signed [SW-1:0]             duty_wide;
    logic signed [DW-1:0]             duty_sat;
    logic                             duty_hit;

    // total and error, clamped to the field range without flagging
    always_comb
    begin
        tot_wide = {cur_a[dpcpi_pkg::CUR_W-1], cur_a} + {cur_b[dpcpi_pkg::CUR_W-1], cur_b};
        if (tot_wide[dpcpi_pkg::CUR_W] != tot_wide[dpcpi_pkg::CUR_W-1])
            tot_sat = tot_wide[dpcpi_pkg::CUR_W] ? {1'b1, {(FW-1){1'b0}}}
                                                 : {1'b0, {(FW-1){1'b1}}};
        else
            tot_sat = tot_wide[FW-1:0];

        setpoint = ctl.boost ? (FW+1)'(dpcpi_pkg::SETPOINT_BOOST)
                             : (FW+1)'(dpcpi_pkg::SETPOINT_BUCK);
        err_wide = setpoint - {tot_sat[FW-1], tot_sat};
        if (err_wide[FW] != err_wide[FW-1])
            err_sat = err_wide[FW] ? {1'b1, {(FW-1){1'b0}}} : {1'b0, {(FW-1){1'b1}}};
        else
            err_sat = err_wide[FW-1:0];
    end

    // saturating accumulator
    always_comb
    begin
        acc_wide = {acc_reg[AW-1], acc_reg} + {{(AW+1-FW){err_sat[FW-1]}}, err_sat};
        acc_hit  = acc_wide[AW] != acc_wide[AW-1];
        if (acc_hit)
            acc_sat = acc_wide[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        else
            acc_sat = acc_wide[AW-1:0];
        acc_next = ctl.acc_load ? acc_sat : acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
    end

    // proportional and integral products
    always_comb
    begin
        kp       = boost2_reg ? dpcpi_pkg::KP_BOOST : dpcpi_pkg::KP_BUCK;
        ki       = boost2_reg ? dpcpi_pkg::KI_BOOST : dpcpi_pkg::KI_BUCK;
        pkp_next = $signed({1'b0, kp}) * err_reg;
        pki_next = $signed({1'b0, ki}) * acc_reg;
    end

    // merge pipeline registers
    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            total_reg  <= tot_sat;
            err_reg    <= err_sat;
            aflag_reg  <= acc_hit;
            boost2_reg <= ctl.boost;
            pkp_reg    <= pkp_next;
            pki_reg    <= pki_next;
            total2_reg <= total_reg;
            err2_reg   <= err_reg;
            aflag2_reg <= aflag_reg;
        end
    end

    // sum, sign by mode, round half up by 2^16 and saturate
    always_comb
    begin
        sum = {{(SW-dpcpi_pkg::PKP_W){pkp_reg[dpcpi_pkg::PKP_W-1]}}, pkp_reg}
            + {{(SW-dpcpi_pkg::PKI_W){pki_reg[dpcpi_pkg::PKI_W-1]}}, pki_reg};
        sum_sel   = boost2_reg ? -sum : sum;
        sum_rnd   = sum_sel + $signed(SW'(longint'(1) << (dpcpi_pkg::ROUND_SHIFT - 1)));
        duty_wide = sum_rnd >>> dpcpi_pkg::ROUND_SHIFT;
        duty_hit  = (duty_wide[SW-1:DW-1] != {(SW-DW+1){1'b0}})
                 && (duty_wide[SW-1:DW-1] != {(SW-DW+1){1'b1}});
        if (duty_hit)
            duty_sat = duty_wide[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        else
            duty_sat = duty_wide[DW-1:0];

        result.duty_command  = duty_sat;
        result.total_current = total2_reg;
        result.control_error = err2_reg;
        result.limit_flag    = aflag2_reg | duty_hit;
    end

endmodule

// ===== sv/dual_phase_current_pi_control.sv =====
// top level of the dual-phase current PI controller
// Takes one pair of phase-current ADC codes per word and returns one word with
// the duty command, total current, error and a saturation flag. A new pair can
// be accepted every clock while the output is not stalled; a stalled output word
// freezes the whole pipeline and the input. Each result passes through seven
// register stages, the first loaded at the accepting edge: four in the two
// conversion lanes (dividend multiply, reciprocal multiply, back-multiply,
// correction), two in the merge (accumulate, PI products) and the output
// register. converter_mode must be written through the cfg port only while no
// word is in flight; the block itself does not enforce this.
module dual_phase_current_pi_control (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: bit 0 converter_mode
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [11:0] phase_a_sample, [23:12] phase_b_sample
    input  logic [23:0] s_axis_tdata,
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [39:0] duty_command, [56:40] total_current, [73:57] control_error,
    // [74] limit_flag, [79:75] zero
    output logic [79:0] m_axis_tdata
);

    localparam int SB = dpcpi_pkg::SAMPLE_BITS;
    localparam int NS = dpcpi_pkg::PIPE_STAGES;

    logic                    mode_reg, mode_next;
    logic                    advance;
    logic [NS-1:0]           valid_reg, valid_next;
    logic                    out_valid_reg, out_valid_next;
    logic [79:0]             tdata_reg, tdata_next;
    dpcpi_pkg::lane_ctl_t    lane_ctl;
    dpcpi_pkg::merge_ctl_t   merge_ctl;
    dpcpi_pkg::result_t      result;
    logic signed [dpcpi_pkg::CUR_W-1:0] cur_a, cur_b;

    // configuration register
    assign cfg_ready = 1'b1;
    assign mode_next = cfg_valid ? cfg_data[0] : mode_reg;

    // whole pipeline moves unless the output word is stalled
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;

    always_comb
    begin
        valid_next     = advance ? {valid_reg[NS-2:0], s_axis_tvalid} : valid_reg;
        out_valid_next = advance ? valid_reg[NS-1] : out_valid_reg;
        tdata_next     = (advance && valid_reg[NS-1])
                       ? {5'b0, result.limit_flag, result.control_error,
                          result.total_current, result.duty_command}
                       : tdata_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tdata_reg <= tdata_next;
    end

    // lane and merge control
    always_comb
    begin
        lane_ctl.advance   = advance;
        lane_ctl.boost     = mode_reg;
        merge_ctl.advance  = advance;
        merge_ctl.acc_load = advance && valid_reg[3];
        merge_ctl.boost    = mode_reg;
    end

    dpcpi_lane u_lane_a (
        .clk     (clk),
        .ctl     (lane_ctl),
        .code    (s_axis_tdata[SB-1:0]),
        .current (cur_a)
    );

    dpcpi_lane u_lane_b (
        .clk     (clk),
        .ctl     (lane_ctl),
        .code    (s_axis_tdata[2*SB-1:SB]),
        .current (cur_b)
    );

    dpcpi_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (merge_ctl),
        .cur_a  (cur_a),
        .cur_b  (cur_b),
        .result (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = tdata_reg;

endmodule

// ===== sv/dpcpi_checker.sv =====
// port-level checker for the current controller, bound to the top level
`include "dual_phase_current_pi_control_macros.svh"

module dpcpi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [0:0]  cfg_data,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata
);

    localparam int FW = dpcpi_pkg::FIELD_W;

    logic [FW-1:0] err_plus_total;
    logic          out_stall;
    logic          setpoint_ok;

    // output word waiting on the sink
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    // error plus total gives back the setpoint of either mode
    assign err_plus_total = m_axis_tdata[73:57] + m_axis_tdata[56:40];
    assign setpoint_ok    = (err_plus_total == FW'(dpcpi_pkg::SETPOINT_BUCK))
                         || (err_plus_total == FW'(dpcpi_pkg::SETPOINT_BOOST));

    `DPCPI_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid, "output word dropped while stalled")
    `DPCPI_ASSERT(a_data_hold, out_stall |=> $stable(m_axis_tdata), "output word changed")
    `DPCPI_ASSERT(a_stall_source, !s_axis_tready |-> out_stall, "input stalled without cause")
    `DPCPI_ASSERT(a_err_setpoint, m_axis_tvalid |-> setpoint_ok, "error and total off setpoint")
    `DPCPI_ASSERT_ANY(a_reset_empty, !rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind dual_phase_current_pi_control dpcpi_checker u_dpcpi_checker (.*);
